### rtl/adsr_pkg.sv
// Shared types and constants for the ADSR envelope pipeline.
package adsr_pkg;

  localparam int TIME_W     = 32;
  localparam int DUR_W      = 31;
  localparam int LVL_W      = 17;
  localparam int Q_W        = 17;
  localparam int NUM_W      = DUR_W + Q_W;
  localparam int DIV_STAGES = Q_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [LVL_W-1:0] ENV_ONE = LVL_W'(65536);

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd4;

  typedef enum logic [2:0] {
    SEG_ZERO    = 3'd0,
    SEG_ATTACK  = 3'd1,
    SEG_DECAY   = 3'd2,
    SEG_SUSTAIN = 3'd3,
    SEG_RELEASE = 3'd4
  } seg_t;

  typedef struct packed {
    logic [DUR_W-1:0] attack;
    logic [DUR_W-1:0] decay;
    logic [DUR_W-1:0] release_len;
    logic [LVL_W-1:0] level;
    logic [DUR_W:0]   sum_ad;
    logic [DUR_W+1:0] sum_ads;
    logic [DUR_W+2:0] sum_adsr;
  } cfg_t;

  typedef struct packed {
    seg_t             seg;
    logic [LVL_W-1:0] level;
    logic [DUR_W-1:0] den;
    logic [NUM_W-1:0] num;
  } front_t;

  typedef struct packed {
    seg_t             seg;
    logic [LVL_W-1:0] level;
    logic [DUR_W-1:0] den;
    logic [DUR_W-1:0] rem;
    logic [Q_W-1:0]   low;
    logic [Q_W-1:0]   q;
  } div_t;

endpackage

### rtl/adsr_envelope_from_time.sv
// Top level of the ADSR envelope generator that maps a time value to a level.
//
// Input channel: in_valid, in_stall, in_time_now (signed time since note start,
// fixed point). Each transaction yields exactly one result transaction on
// out_valid, out_stall, out_envelope (Q1.16, 65536 is full scale).
// Configuration channel: cfg_valid, cfg_ready, cfg_index, cfg_data. cfg_ready
// is always high; index 0..4 selects attack, decay, sustain time, sustain
// level and release time, other indexes are ignored. Write only while idle.
// Path from input to output valid: an input register, segment decode, operand
// select, a 31x17 multiply, a 17 stage restoring divider with one quotient bit
// per stage, and the output register. Throughput is one transaction per cycle
// while the receiver does not stall; the divider stages set the depth.
// Every stage has a valid bit and advances when the stage after it is empty
// or moving, so bubbles are squeezed out and a stalled receiver holds data in
// place without loss; in_stall rises only once the pipeline is full.
// Reset empties the pipeline and loads the default envelope settings.
module adsr_envelope_from_time (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [adsr_pkg::TIME_W-1:0]  in_time_now,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [adsr_pkg::LVL_W-1:0]          out_envelope,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [adsr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  adsr_pkg::cfg_t   cfg;
  adsr_pkg::front_t front_data;
  adsr_pkg::div_t   div_data;
  logic             front_ready, front_valid;
  logic             div_ready, div_valid;
  logic             out_ready;
  logic             out_valid_r;
  logic [adsr_pkg::LVL_W-1:0] env_nxt, env_r;

  adsr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  adsr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (front_ready),
    .up_time  (in_time_now),
    .dn_valid (front_valid),
    .dn_ready (div_ready),
    .dn_data  (front_data)
  );

  adsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (front_valid),
    .up_ready (div_ready),
    .up_data  (front_data),
    .dn_valid (div_valid),
    .dn_ready (out_ready),
    .dn_data  (div_data)
  );

  assign in_stall     = !front_ready;
  assign out_ready    = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_envelope = env_r;

  always_comb begin
    unique case (div_data.seg)
      adsr_pkg::SEG_ATTACK:  env_nxt = div_data.q;
      adsr_pkg::SEG_DECAY:   env_nxt = adsr_pkg::ENV_ONE - div_data.q;
      adsr_pkg::SEG_SUSTAIN: env_nxt = div_data.level;
      adsr_pkg::SEG_RELEASE: env_nxt = div_data.level - div_data.q;
      default:               env_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && div_valid) env_r <= env_nxt;
  end

endmodule

### rtl/adsr_cfg.sv
// Configuration registers and the segment boundary sums derived from them.
module adsr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [adsr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output adsr_pkg::cfg_t                    cfg
);

  logic [adsr_pkg::DUR_W-1:0] attack_r;
  logic [adsr_pkg::DUR_W-1:0] decay_r;
  logic [adsr_pkg::DUR_W-1:0] sustain_r;
  logic [adsr_pkg::LVL_W-1:0] level_r;
  logic [adsr_pkg::DUR_W-1:0] release_r;
  logic [adsr_pkg::LVL_W-1:0] level_clip_r;
  logic [adsr_pkg::DUR_W:0]   sum_ad_r;
  logic [adsr_pkg::DUR_W+1:0] sum_ads_r;
  logic [adsr_pkg::DUR_W+2:0] sum_adsr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= adsr_pkg::DUR_W'(3277);
      decay_r   <= adsr_pkg::DUR_W'(6554);
      sustain_r <= adsr_pkg::DUR_W'(65536);
      level_r   <= adsr_pkg::LVL_W'(39322);
      release_r <= adsr_pkg::DUR_W'(32768);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        adsr_pkg::REG_ATTACK:  attack_r  <= cfg_data[adsr_pkg::DUR_W-1:0];
        adsr_pkg::REG_DECAY:   decay_r   <= cfg_data[adsr_pkg::DUR_W-1:0];
        adsr_pkg::REG_SUSTAIN: sustain_r <= cfg_data[adsr_pkg::DUR_W-1:0];
        adsr_pkg::REG_LEVEL:   level_r   <= cfg_data[adsr_pkg::LVL_W-1:0];
        adsr_pkg::REG_RELEASE: release_r <= cfg_data[adsr_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    level_clip_r <= (level_r > adsr_pkg::ENV_ONE) ? adsr_pkg::ENV_ONE : level_r;
    sum_ad_r     <= {1'b0, attack_r} + {1'b0, decay_r};
    sum_ads_r    <= {2'b0, attack_r} + {2'b0, decay_r} + {2'b0, sustain_r};
    sum_adsr_r   <= {3'b0, attack_r} + {3'b0, decay_r} + {3'b0, sustain_r}
                  + {3'b0, release_r};
  end

  always_comb begin
    cfg.attack      = attack_r;
    cfg.decay       = decay_r;
    cfg.release_len = release_r;
    cfg.level       = level_clip_r;
    cfg.sum_ad      = sum_ad_r;
    cfg.sum_ads     = sum_ads_r;
    cfg.sum_adsr    = sum_adsr_r;
  end

endmodule

### rtl/adsr_front.sv
// Front pipeline: input register, segment decode, operand select and multiply.
module adsr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  adsr_pkg::cfg_t                      cfg,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  logic signed [adsr_pkg::TIME_W-1:0]  up_time,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output adsr_pkg::front_t                    dn_data
);

  logic                              va_r, vb_r, vc_r, vd_r;
  logic                              rdy_a, rdy_b, rdy_c, rdy_d;
  logic signed [adsr_pkg::TIME_W-1:0] ta_r;

  adsr_pkg::seg_t             seg_b_nxt, seg_b_r, seg_c_r;
  logic [adsr_pkg::DUR_W-1:0] tu_a, tu_b_r;
  logic [adsr_pkg::DUR_W-1:0] x_c_nxt, x_c_r;
  logic [adsr_pkg::LVL_W-1:0] k_c_nxt, k_c_r;
  logic [adsr_pkg::DUR_W-1:0] den_c_nxt, den_c_r;
  logic [adsr_pkg::LVL_W-1:0] lvl_c_r;
  adsr_pkg::front_t           d_r;

  assign rdy_d    = !vd_r || dn_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign up_ready = rdy_a;
  assign dn_valid = vd_r;
  assign dn_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= up_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
    end
  end

  assign tu_a = ta_r[adsr_pkg::DUR_W-1:0];

  always_comb begin
    priority if (ta_r[adsr_pkg::TIME_W-1]) begin
      seg_b_nxt = adsr_pkg::SEG_ZERO;
    end else if (tu_a <= cfg.attack) begin
      seg_b_nxt = (cfg.attack == '0) ? adsr_pkg::SEG_ZERO : adsr_pkg::SEG_ATTACK;
    end else if ({1'b0, tu_a} <= cfg.sum_ad) begin
      seg_b_nxt = (cfg.decay == '0) ? adsr_pkg::SEG_ZERO : adsr_pkg::SEG_DECAY;
    end else if ({2'b0, tu_a} <= cfg.sum_ads) begin
      seg_b_nxt = adsr_pkg::SEG_SUSTAIN;
    end else if ({3'b0, tu_a} <= cfg.sum_adsr) begin
      seg_b_nxt = (cfg.release_len == '0) ? adsr_pkg::SEG_ZERO : adsr_pkg::SEG_RELEASE;
    end else begin
      seg_b_nxt = adsr_pkg::SEG_ZERO;
    end
  end

  always_comb begin
    x_c_nxt   = '0;
    k_c_nxt   = '0;
    den_c_nxt = cfg.release_len;
    unique case (seg_b_r)
      adsr_pkg::SEG_ATTACK: begin
        x_c_nxt   = tu_b_r;
        k_c_nxt   = adsr_pkg::ENV_ONE;
        den_c_nxt = cfg.attack;
      end
      adsr_pkg::SEG_DECAY: begin
        x_c_nxt   = tu_b_r - cfg.attack;
        k_c_nxt   = adsr_pkg::ENV_ONE - cfg.level;
        den_c_nxt = cfg.decay;
      end
      adsr_pkg::SEG_RELEASE: begin
        x_c_nxt   = tu_b_r - cfg.sum_ads[adsr_pkg::DUR_W-1:0];
        k_c_nxt   = cfg.level;
        den_c_nxt = cfg.release_len;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy_a && up_valid) ta_r <= up_time;
    if (rdy_b && va_r) begin
      seg_b_r <= seg_b_nxt;
      tu_b_r  <= tu_a;
    end
    if (rdy_c && vb_r) begin
      seg_c_r <= seg_b_r;
      x_c_r   <= x_c_nxt;
      k_c_r   <= k_c_nxt;
      den_c_r <= den_c_nxt;
      lvl_c_r <= cfg.level;
    end
    if (rdy_d && vc_r) begin
      d_r.seg   <= seg_c_r;
      d_r.level <= lvl_c_r;
      d_r.den   <= den_c_r;
      d_r.num   <= {{adsr_pkg::Q_W{1'b0}}, x_c_r} * {{adsr_pkg::DUR_W{1'b0}}, k_c_r};
    end
  end

endmodule

### rtl/adsr_div.sv
// Restoring divider pipeline, one quotient bit per stage.
module adsr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  adsr_pkg::front_t  up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output adsr_pkg::div_t    dn_data
);

  localparam int N = adsr_pkg::DIV_STAGES;

  function automatic adsr_pkg::div_t div_step(input adsr_pkg::div_t s);
    adsr_pkg::div_t             o;
    logic [adsr_pkg::DUR_W:0]   trial;
    logic [adsr_pkg::DUR_W:0]   diff;
    o     = s;
    trial = {s.rem, s.low[adsr_pkg::Q_W-1]};
    diff  = trial - {1'b0, s.den};
    if (trial >= {1'b0, s.den}) begin
      o.rem = diff[adsr_pkg::DUR_W-1:0];
      o.q   = {s.q[adsr_pkg::Q_W-2:0], 1'b1};
    end else begin
      o.rem = trial[adsr_pkg::DUR_W-1:0];
      o.q   = {s.q[adsr_pkg::Q_W-2:0], 1'b0};
    end
    o.low = {s.low[adsr_pkg::Q_W-2:0], 1'b0};
    return o;
  endfunction

  adsr_pkg::div_t init;
  adsr_pkg::div_t st_r [N];
  logic           v_r  [N];
  logic           rdy  [N+1];

  always_comb begin
    init.seg   = up_data.seg;
    init.level = up_data.level;
    init.den   = up_data.den;
    init.rem   = up_data.num[adsr_pkg::NUM_W-1:adsr_pkg::Q_W];
    init.low   = up_data.num[adsr_pkg::Q_W-1:0];
    init.q     = '0;
  end

  assign rdy[N]   = dn_ready;
  assign up_ready = rdy[0];
  assign dn_valid = v_r[N-1];
  assign dn_data  = st_r[N-1];

  for (genvar i = 0; i < N; i++) begin : g_stage
    adsr_pkg::div_t src;
    logic           src_v;

    if (i == 0) begin : g_first
      assign src   = init;
      assign src_v = up_valid;
    end else begin : g_next
      assign src   = st_r[i-1];
      assign src_v = v_r[i-1];
    end

    assign rdy[i] = !v_r[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && src_v) st_r[i] <= div_step(src);
    end
  end

endmodule

### sim/adsr_envelope_checker.sv
`timescale 1ns / 100ps
// Checker that predicts and compares the envelope levels of the ADSR envelope block.
module adsr_envelope_checker
  import adsr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [TIME_W-1:0] in_time_now,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [LVL_W-1:0]        out_envelope,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output int                      fail_count,
  output int                      pending,
  output int                      results_seen
);

  logic [DUR_W-1:0] attack_len;
  logic [DUR_W-1:0] decay_len;
  logic [DUR_W-1:0] sustain_len;
  logic [DUR_W-1:0] release_len;
  logic [LVL_W-1:0] level_set;
  logic [LVL_W-1:0] expected_levels[$];

  function automatic logic [LVL_W-1:0] level_at(input logic signed [TIME_W-1:0] time_val);
    longint t, a, d, s, r, full, lvl, e;
    t = longint'(time_val);
    a = longint'(attack_len);
    d = longint'(decay_len);
    s = longint'(sustain_len);
    r = longint'(release_len);
    full = longint'(ENV_ONE);
    lvl = (level_set > ENV_ONE) ? full : longint'(level_set);
    if (t < 0) begin
      e = 0;
    end else if (t <= a) begin
      e = (a == 0) ? 0 : (t * full) / a;
    end else if (t <= a + d) begin
      e = (d == 0) ? 0 : full - ((t - a) * (full - lvl)) / d;
    end else if (t <= a + d + s) begin
      e = lvl;
    end else if (t <= a + d + s + r) begin
      e = (r == 0) ? 0 : lvl - ((t - a - d - s) * lvl) / r;
    end else begin
      e = 0;
    end
    if (e > full) e = full;
    if (e < 0) e = 0;
    return LVL_W'(e);
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    logic [LVL_W-1:0] want;
    if (!rst_n) begin
      attack_len <= DUR_W'(3277);
      decay_len <= DUR_W'(6554);
      sustain_len <= DUR_W'(65536);
      level_set <= LVL_W'(39322);
      release_len <= DUR_W'(32768);
      expected_levels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_levels.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: envelope %0d arrived with no transaction outstanding",
                     out_envelope);
        end else begin
          want = expected_levels.pop_front();
          if (out_envelope !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: envelope mismatch, expected %0d, got %0d", want, out_envelope);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_levels.push_back(level_at(in_time_now));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ATTACK:  attack_len <= cfg_data[DUR_W-1:0];
          REG_DECAY:   decay_len <= cfg_data[DUR_W-1:0];
          REG_SUSTAIN: sustain_len <= cfg_data[DUR_W-1:0];
          REG_LEVEL:   level_set <= cfg_data[LVL_W-1:0];
          REG_RELEASE: release_len <= cfg_data[DUR_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_levels.size();
  end

endmodule

### sim/tb_adsr_envelope_from_time.sv
`timescale 1ns / 100ps
// Testbench top for the ADSR envelope block: stimulus, settings and the final verdict.
module tb_adsr_envelope_from_time;
  import adsr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_SETTINGS = 10;
  localparam int RANDOM_PER_SETTING = 195;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 120;
  localparam longint TIME_MAX = 64'sd2147483647;
  localparam longint TIME_MIN = -64'sd2147483648;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_RELEASE + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = '1;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [TIME_W-1:0] in_time_now;
  logic                     out_valid;
  logic                     out_stall;
  logic [LVL_W-1:0]         out_envelope;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  int fail_count;
  int pending;
  int results_seen;
  int cycles = 0;
  int sent = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  longint atk_len, dec_len, sus_len, rel_len;

  adsr_envelope_from_time dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_time_now  (in_time_now),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_envelope (out_envelope),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  adsr_envelope_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_time_now  (in_time_now),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_envelope (out_envelope),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d transactions outstanding", cycles, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver stalls at random, or for a long counted stretch when asked.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 32);
      end
    end
  end

  task automatic send_time(input logic [TIME_W-1:0] t);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_time_now <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_setting(input logic [CFG_DATA_W-1:0] a, input logic [CFG_DATA_W-1:0] d,
                              input logic [CFG_DATA_W-1:0] s, input logic [CFG_DATA_W-1:0] lvl,
                              input logic [CFG_DATA_W-1:0] r);
    write_reg(REG_ATTACK, a);
    write_reg(REG_DECAY, d);
    write_reg(REG_SUSTAIN, s);
    write_reg(REG_LEVEL, lvl);
    write_reg(REG_RELEASE, r);
    if ($urandom_range(1))
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    atk_len = longint'(a);
    dec_len = longint'(d);
    sus_len = longint'(s);
    rel_len = longint'(r);
  endtask

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(3))
      0: return DUR_W'($urandom_range(15));
      1: return DUR_W'($urandom_range(65535));
      2: return DUR_W'($urandom >> $urandom_range(31));
      default: return DUR_W'($urandom);
    endcase
  endfunction

  initial begin
    int k, n, i, seg;
    longint edges[5];
    longint tt;
    longint unsigned rnd, span;
    logic [CFG_DATA_W-1:0] level_data;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_time_now = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    atk_len = 3277;
    dec_len = 6554;
    sus_len = 65536;
    rel_len = 32768;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (k = 0; k < NUM_SETTINGS; k++) begin
      if (k > 0) begin
        wait_idle();
        case (k)
          1: load_setting('0, '0, '0, '0, '0);
          2: load_setting('1, '1, '1, CFG_DATA_W'(ENV_ONE), '1);
          3: load_setting(CFG_DATA_W'(1), CFG_DATA_W'(1), '0, '1, CFG_DATA_W'(1));
          default: begin
            case ($urandom_range(4))
              0: level_data = '0;
              1: level_data = CFG_DATA_W'(ENV_ONE);
              2: level_data = CFG_DATA_W'($urandom_range(65536));
              3: level_data = CFG_DATA_W'($urandom_range(65536, 131071));
              default: level_data = CFG_DATA_W'($urandom);
            endcase
            load_setting(pick_duration(), pick_duration(), pick_duration(), level_data,
                         pick_duration());
          end
        endcase
      end
      edges[0] = 0;
      edges[1] = atk_len;
      edges[2] = edges[1] + dec_len;
      edges[3] = edges[2] + sus_len;
      edges[4] = edges[3] + rel_len;

      if (k <= 1) begin
        send_time(0);
        send_time(1);
        send_time('1);
      end
      if (k == 0) begin
        send_time(32'h8000_0000);
        send_time(32'h7FFF_FFFF);
        for (i = 0; i < 4; i++) begin
          send_time(TIME_W'(edges[i] + (edges[i+1] - edges[i]) / 2));
          send_time(TIME_W'(edges[i+1]));
          send_time(TIME_W'(edges[i+1] + 1));
        end
      end

      calm = (k == 3);
      for (n = 0; n < RANDOM_PER_SETTING; n++) begin
        if (k == 2 && n == 20) hold_req = 1'b1;
        if (k == 5 && n == 100) begin
          in_valid <= 1'b0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
        end
        case ($urandom_range(9))
          0, 1: tt = longint'($signed($urandom));
          2: tt = -longint'($urandom_range(8));
          3, 4, 5: tt = edges[$urandom_range(4)] + longint'($urandom_range(6)) - 3;
          default: begin
            seg = $urandom_range(3);
            span = edges[seg+1] - edges[seg];
            rnd = {$urandom, $urandom};
            tt = edges[seg] + longint'(rnd % (span + 1));
          end
        endcase
        if (tt > TIME_MAX) tt = TIME_MAX;
        if (tt < TIME_MIN) tt = TIME_MIN;
        send_time(TIME_W'(tt));
      end
      in_valid <= 1'b0;
      calm = 1'b0;
    end

    wait_idle();
    $display("Sent %0d time values under %0d envelope settings, zero-length, full-range and",
             sent, NUM_SETTINGS);
    $display("over-scale ones among them, with an output hold-off; %0d levels compared.",
             results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### adsr_envelope_from_time.f
rtl/adsr_pkg.sv
rtl/adsr_cfg.sv
rtl/adsr_front.sv
rtl/adsr_div.sv
rtl/adsr_envelope_from_time.sv
sim/adsr_envelope_checker.sv
sim/tb_adsr_envelope_from_time.sv
